### sv/pptint_pkg.sv
// pptint_pkg: field widths, function codes and register indexes of the pair potential table
// shared by the channel interfaces and the top level
// no dependencies
`default_nettype none

package pptint_pkg;

	localparam int DATA_W  = 32;
	localparam int DIST_W  = 32;
	localparam int TYPE_W  = 2;
	localparam int INDEX_W = 10;
	localparam int ADDR_W  = 5;
	localparam int FRAC_W  = 16;

	typedef enum logic {
		FUNC_WRITE = 1'b0,
		FUNC_EVAL  = 1'b1
	} func_t;

	typedef enum logic {
		TBL_LIKE   = 1'b0,
		TBL_UNLIKE = 1'b1
	} tbl_t;

	typedef enum logic [2:0] {
		REG_LIKE_STEP     = 3'd0,
		REG_LIKE_INV      = 3'd1,
		REG_LIKE_CUT      = 3'd2,
		REG_UNLIKE_STEP   = 3'd3,
		REG_UNLIKE_INV    = 3'd4,
		REG_UNLIKE_CUT    = 3'd5,
		REG_SPARE6        = 3'd6,
		REG_SPARE7        = 3'd7
	} reg_idx_t;

	localparam logic [DATA_W-1:0] STEP_RESET = 32'h0001_0000;
	localparam logic [DATA_W-1:0] INV_RESET  = 32'h0001_0000;
	localparam logic [DATA_W-1:0] CUT_RESET  = 32'h0000_0000;

endpackage

`default_nettype wire

### sv/pptint_req_if.sv
// pptint_req_if: valid/ready channel carrying table writes and pair evaluations
// depends on pptint_pkg for field widths and the function code type
`default_nettype none

interface pptint_req_if;
	logic                                    valid;
	logic                                    ready;
	pptint_pkg::func_t                       func;
	logic [pptint_pkg::TYPE_W-1:0]           type_a;
	logic [pptint_pkg::TYPE_W-1:0]           type_b;
	logic [pptint_pkg::DIST_W-1:0]           dist_sq;
	logic                                    table_sel;
	logic [pptint_pkg::INDEX_W-1:0]          entry_index;
	logic signed [pptint_pkg::DATA_W-1:0]    entry_value;

	modport source (
		output valid, func, type_a, type_b, dist_sq, table_sel, entry_index, entry_value,
		input  ready
	);
	modport sink (
		input  valid, func, type_a, type_b, dist_sq, table_sel, entry_index, entry_value,
		output ready
	);
endinterface

`default_nettype wire

### sv/pptint_rsp_if.sv
// pptint_rsp_if: valid/ready channel carrying interpolated potentials
// depends on pptint_pkg for field widths
`default_nettype none

interface pptint_rsp_if;
	logic                                    valid;
	logic                                    ready;
	logic signed [pptint_pkg::DATA_W-1:0]    potential;
	logic                                    in_range;

	modport source (
		output valid, potential, in_range,
		input  ready
	);
	modport sink (
		input  valid, potential, in_range,
		output ready
	);
endinterface

`default_nettype wire

### sv/pair_potential_table_interp.sv
// pair_potential_table_interp: two pair potential tables with linear interpolation
// depends on pptint_pkg, pptint_req_if, pptint_rsp_if and pptint_ram
//
//   channel   direction  handshake          carries
//   pairs     in         valid / ready      func, types, dist_sq, table write fields
//   results   out        valid / ready      potential, in_range (one per evaluate item)
//   apb       in         psel / penable     six 32-bit step, reciprocal and cutoff registers
//
// one item per cycle sustained while the results channel takes them; the distance
// multiplier, the registered table read and the interpolation multiplier each sit
// in a stage of their own
// reset clears the valid bits and returns the registers to their reset values; the tables are not cleared
// a stalled output holds its item, bubbles in the pipeline close up meanwhile
`default_nettype none

module pair_potential_table_interp #(
	parameter int TABLE_DEPTH = 1024
) (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	pptint_req_if.sink                            pairs,
	pptint_rsp_if.source                          results,
	input  wire logic                             psel,
	input  wire logic                             penable,
	input  wire logic                             pwrite,
	input  wire logic [pptint_pkg::ADDR_W-1:0]    paddr,
	input  wire logic [pptint_pkg::DATA_W-1:0]    pwdata,
	output logic      [pptint_pkg::DATA_W-1:0]    prdata,
	output logic                                  pready
);

	localparam int AW       = $clog2(TABLE_DEPTH);
	localparam int RAM_AW   = AW + 1;
	localparam int RAM_D    = 2 * (1 << AW);
	localparam int DW       = pptint_pkg::DATA_W;
	localparam int FW       = pptint_pkg::FRAC_W;
	localparam logic [DW-1:0] LAST_IDX = DW'(TABLE_DEPTH - 1);

	// configuration registers
	logic [DW-1:0] like_step_q, like_inv_q, like_cut_q;
	logic [DW-1:0] unlike_step_q, unlike_inv_q, unlike_cut_q;
	pptint_pkg::reg_idx_t reg_idx;
	logic cfg_wr;

	assign pready  = 1'b1;
	assign reg_idx = pptint_pkg::reg_idx_t'(paddr[pptint_pkg::ADDR_W-1:2]);
	assign cfg_wr  = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			like_step_q   <= pptint_pkg::STEP_RESET;
			like_inv_q    <= pptint_pkg::INV_RESET;
			like_cut_q    <= pptint_pkg::CUT_RESET;
			unlike_step_q <= pptint_pkg::STEP_RESET;
			unlike_inv_q  <= pptint_pkg::INV_RESET;
			unlike_cut_q  <= pptint_pkg::CUT_RESET;
		end else if (cfg_wr) begin
			case (reg_idx)
				pptint_pkg::REG_LIKE_STEP:   like_step_q   <= pwdata;
				pptint_pkg::REG_LIKE_INV:    like_inv_q    <= pwdata;
				pptint_pkg::REG_LIKE_CUT:    like_cut_q    <= pwdata;
				pptint_pkg::REG_UNLIKE_STEP: unlike_step_q <= pwdata;
				pptint_pkg::REG_UNLIKE_INV:  unlike_inv_q  <= pwdata;
				pptint_pkg::REG_UNLIKE_CUT:  unlike_cut_q  <= pwdata;
				default: ;
			endcase
		end
	end

	always_comb begin
		case (reg_idx)
			pptint_pkg::REG_LIKE_STEP:   prdata = like_step_q;
			pptint_pkg::REG_LIKE_INV:    prdata = like_inv_q;
			pptint_pkg::REG_LIKE_CUT:    prdata = like_cut_q;
			pptint_pkg::REG_UNLIKE_STEP: prdata = unlike_step_q;
			pptint_pkg::REG_UNLIKE_INV:  prdata = unlike_inv_q;
			pptint_pkg::REG_UNLIKE_CUT:  prdata = unlike_cut_q;
			default:                     prdata = '0;
		endcase
	end

	// stage valid bits and the per-stage advance chain
	logic v1_s1, v2_s2, v3_s3, v4_s4, v5_s5, out_valid_q;
	logic adv_out, adv5, adv4, adv3, adv2, adv1;

	assign adv_out = !out_valid_q || results.ready;
	assign adv5    = !v5_s5 || adv_out;
	assign adv4    = !v4_s4 || adv5;
	assign adv3    = !v3_s3 || adv4;
	assign adv2    = !v2_s2 || adv3;
	assign adv1    = !v1_s1 || adv2;
	assign pairs.ready = adv1;

	// stage 1: captured item
	pptint_pkg::func_t func_s1;
	logic              like_s1;
	logic [DW-1:0]     dist_s1;
	logic              sel_s1;
	logic [pptint_pkg::INDEX_W-1:0] idx_s1;
	logic [DW-1:0]     val_s1;

	// stage 2: distance product and range flags
	pptint_pkg::func_t func_s2;
	logic              tbl_s2;
	logic [pptint_pkg::INDEX_W-1:0] idx_s2;
	logic [DW-1:0]     val_s2;
	logic [2*DW-1:FW]  prod_s2;
	logic              below_s2, beyond_s2;

	// stage 3: table entries (ram output) and fraction
	logic [FW:0]       frac_s3;
	logic              beyond_s3;
	logic [DW-1:0]     lo_raw, hi_raw;

	// stage 4: entry difference
	logic signed [DW:0]   diff_s4;
	logic signed [DW-1:0] lo_s4;
	logic [FW:0]          frac_s4;
	logic                 beyond_s4;

	// stage 5: scaled difference
	logic signed [2*DW-FW+1:0] scaled_s5;
	logic signed [DW-1:0]      lo_s5;
	logic                      beyond_s5;

	// output register
	logic signed [DW-1:0] pot_q;
	logic                 in_range_q;

	// table selection on the captured item
	logic [DW-1:0] sel_step, sel_inv, sel_cut;
	logic [2*DW-1:0] dist_prod;
	logic below_c;

	always_comb begin
		sel_step  = like_s1 ? like_step_q : unlike_step_q;
		sel_inv   = like_s1 ? like_inv_q  : unlike_inv_q;
		sel_cut   = like_s1 ? like_cut_q  : unlike_cut_q;
		dist_prod = dist_s1 * sel_inv;
		below_c   = dist_s1 < sel_step;
	end

	// index clamp: below one step or a zero index reads entry 0 on both ports with
	// no fraction, past the last entry reads the last entry with a full fraction
	logic [DW-1:0] idx_raw;
	logic [AW-1:0] idx_hi, idx_lo;
	logic [FW:0]   frac_c;
	logic          wr_in_range;
	logic          ram_we, ram_re;

	always_comb begin
		idx_raw = prod_s2[2*DW-1:DW];
		frac_c  = {1'b0, prod_s2[DW-1:FW]};
		idx_hi  = AW'(idx_raw);
		idx_lo  = '0;
		if (below_s2 || idx_raw == '0) begin
			idx_hi = '0;
			frac_c = '0;
		end else begin
			if (idx_raw > LAST_IDX) begin
				idx_hi = AW'(TABLE_DEPTH - 1);
				frac_c = {1'b1, {FW{1'b0}}};
			end
			idx_lo = idx_hi - AW'(1);
		end
	end

	assign wr_in_range = 32'(idx_s2) < TABLE_DEPTH;
	assign ram_we = adv3 && v2_s2 && func_s2 == pptint_pkg::FUNC_WRITE && wr_in_range;
	assign ram_re = adv3 && v2_s2 && func_s2 == pptint_pkg::FUNC_EVAL;

	// both tables share one ram, the table bit on top of the address
	pptint_ram #(
		.WIDTH (DW),
		.DEPTH (RAM_D)
	) u_tables (
		.clk     (clk),
		.we      (ram_we),
		.waddr   ({tbl_s2, AW'(idx_s2)}),
		.wdata   (val_s2),
		.re      (ram_re),
		.raddr_a ({tbl_s2, idx_lo}),
		.raddr_b ({tbl_s2, idx_hi}),
		.rdata_a (lo_raw),
		.rdata_b (hi_raw)
	);

	logic signed [2*DW-FW+2:0] scaled_c;
	logic signed [DW+1:0]      sum_c;

	always_comb begin
		scaled_c = diff_s4 * $signed({1'b0, frac_s4});
		// arithmetic shift gives the floor of the scaled difference
		sum_c    = {{2{lo_s5[DW-1]}}, lo_s5} + scaled_s5[2*DW-FW+1:FW];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v1_s1       <= 1'b0;
			v2_s2       <= 1'b0;
			v3_s3       <= 1'b0;
			v4_s4       <= 1'b0;
			v5_s5       <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (adv1) begin
				v1_s1 <= pairs.valid;
			end
			if (adv2) begin
				v2_s2 <= v1_s1;
			end
			// write items end at the ram
			if (adv3) begin
				v3_s3 <= v2_s2 && func_s2 == pptint_pkg::FUNC_EVAL;
			end
			if (adv4) begin
				v4_s4 <= v3_s3;
			end
			if (adv5) begin
				v5_s5 <= v4_s4;
			end
			if (adv_out) begin
				out_valid_q <= v5_s5;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv1 && pairs.valid) begin
			func_s1 <= pairs.func;
			like_s1 <= pairs.type_a[pptint_pkg::TYPE_W-1] == pairs.type_b[pptint_pkg::TYPE_W-1];
			dist_s1 <= pairs.dist_sq;
			sel_s1  <= pairs.table_sel;
			idx_s1  <= pairs.entry_index;
			val_s1  <= pairs.entry_value;
		end
		if (adv2) begin
			func_s2   <= func_s1;
			tbl_s2    <= (func_s1 == pptint_pkg::FUNC_WRITE) ? sel_s1
				: (like_s1 ? pptint_pkg::TBL_LIKE : pptint_pkg::TBL_UNLIKE);
			idx_s2    <= idx_s1;
			val_s2    <= val_s1;
			prod_s2   <= dist_prod[2*DW-1:FW];
			below_s2  <= below_c;
			beyond_s2 <= !below_c && dist_s1 >= sel_cut;
		end
		if (adv3) begin
			frac_s3   <= frac_c;
			beyond_s3 <= beyond_s2;
		end
		if (adv4) begin
			diff_s4   <= {hi_raw[DW-1], hi_raw} - {lo_raw[DW-1], lo_raw};
			lo_s4     <= lo_raw;
			frac_s4   <= frac_s3;
			beyond_s4 <= beyond_s3;
		end
		if (adv5) begin
			scaled_s5 <= scaled_c[2*DW-FW+1:0];
			lo_s5     <= lo_s4;
			beyond_s5 <= beyond_s4;
		end
		if (adv_out) begin
			pot_q      <= beyond_s5 ? '0 : sum_c[DW-1:0];
			in_range_q <= !beyond_s5;
		end
	end

	assign results.valid     = out_valid_q;
	assign results.potential = pot_q;
	assign results.in_range  = in_range_q;

	// a write item never turns into a result
	a_write_no_result: assert property (@(posedge clk) disable iff (!arst_n)
		ram_we |=> !v3_s3)
		else $error("table write produced a stage 3 item");

	// forced-zero results carry no potential
	a_cutoff_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && !in_range_q |-> pot_q == '0)
		else $error("out-of-range result with non-zero potential");

	// a full fraction only comes from the saturated index
	a_full_frac: assert property (@(posedge clk) disable iff (!arst_n)
		v3_s3 && frac_s3[FW] |-> frac_s3[FW-1:0] == '0)
		else $error("fraction above one");

	// input back-pressure only when the whole pipeline is occupied
	a_ready_full: assert property (@(posedge clk) disable iff (!arst_n)
		!pairs.ready |-> v1_s1 && v2_s2 && out_valid_q)
		else $error("input stalled with room in the pipeline");

endmodule

`default_nettype wire

### sv/pptint_ram.sv
// pptint_ram: generic ram, one write port and two registered read ports
// no dependencies
`default_nettype none

module pptint_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 2048
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr_a,
	input  wire logic [$clog2(DEPTH)-1:0] raddr_b,
	output logic      [WIDTH-1:0]         rdata_a,
	output logic      [WIDTH-1:0]         rdata_b
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata_a <= mem[raddr_a];
			rdata_b <= mem[raddr_b];
		end
	end

endmodule

`default_nettype wire

### bench/pptint_checker.sv
// pptint_checker: predicts the potential and in-range flag of every evaluate item
// and compares them with the results channel; depends on pptint_pkg and both
// channel interfaces
module pptint_checker #(
	parameter int DEPTH = 1024
) (
	input  logic                               clk,
	input  logic                               arst_n,
	pptint_req_if                              pairs,
	pptint_rsp_if                              results,
	input  logic                               psel,
	input  logic                               penable,
	input  logic                               pwrite,
	input  logic [pptint_pkg::ADDR_W-1:0]      paddr,
	input  logic [pptint_pkg::DATA_W-1:0]      pwdata,
	input  logic                               pready,
	output int                                 errors,
	output int                                 pending
);
	timeunit 1ns;
	timeprecision 1ps;
	import pptint_pkg::*;

	typedef struct packed {
		logic signed [DATA_W-1:0] potential;
		logic                     in_range;
	} outcome_t;

	outcome_t                 outcome_q[$];
	outcome_t                 want;
	int                       fail_tally;
	logic signed [DATA_W-1:0] pot_tbl [2][DEPTH];
	logic [DATA_W-1:0]        step_r [2];
	logic [DATA_W-1:0]        inv_r [2];
	logic [DATA_W-1:0]        cut_r [2];

	function automatic outcome_t interpolate(tbl_t t, logic [DIST_W-1:0] d);
		logic [63:0] prod;
		logic [31:0] idx;
		longint      frac;
		longint      lo;
		longint      hi;
		outcome_t    o;
		o.in_range = 1'b1;
		if (d < step_r[t]) begin
			o.potential = pot_tbl[t][0];
		end else if (d >= cut_r[t]) begin
			o.potential = '0;
			o.in_range  = 1'b0;
		end else begin
			prod = {32'd0, d} * {32'd0, inv_r[t]};
			idx  = prod[63:32];
			frac = prod[31:16];
			if (idx == 0) begin
				idx  = 1;
				frac = 0;
			end else if (idx > DEPTH - 1) begin
				idx  = DEPTH - 1;
				frac = 65536;
			end
			lo = pot_tbl[t][idx - 1];
			hi = pot_tbl[t][idx];
			o.potential = DATA_W'(lo + (((hi - lo) * frac) >>> FRAC_W));
		end
		return o;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_r[TBL_LIKE]   = STEP_RESET;
			step_r[TBL_UNLIKE] = STEP_RESET;
			inv_r[TBL_LIKE]    = INV_RESET;
			inv_r[TBL_UNLIKE]  = INV_RESET;
			cut_r[TBL_LIKE]    = CUT_RESET;
			cut_r[TBL_UNLIKE]  = CUT_RESET;
			outcome_q.delete();
			fail_tally = 0;
			errors  <= 0;
			pending <= 0;
		end else begin
			if (psel && penable && pwrite && pready && paddr[1:0] == 2'b00) begin
				case (reg_idx_t'(paddr[ADDR_W-1:2]))
					REG_LIKE_STEP:   step_r[TBL_LIKE]   = pwdata;
					REG_LIKE_INV:    inv_r[TBL_LIKE]    = pwdata;
					REG_LIKE_CUT:    cut_r[TBL_LIKE]    = pwdata;
					REG_UNLIKE_STEP: step_r[TBL_UNLIKE] = pwdata;
					REG_UNLIKE_INV:  inv_r[TBL_UNLIKE]  = pwdata;
					REG_UNLIKE_CUT:  cut_r[TBL_UNLIKE]  = pwdata;
					default: ;
				endcase
			end
			// results first: a result never belongs to the item taken at the same edge
			if (results.valid && results.ready) begin
				if (outcome_q.size() == 0) begin
					$display("%0t: unexpected result, expected none, actual potential %h in_range %b",
						$time, results.potential, results.in_range);
					fail_tally++;
				end else begin
					want = outcome_q.pop_front();
					if (results.potential !== want.potential) begin
						$display("%0t: potential mismatch, expected %h actual %h",
							$time, want.potential, results.potential);
						fail_tally++;
					end
					if (results.in_range !== want.in_range) begin
						$display("%0t: in_range mismatch, expected %b actual %b",
							$time, want.in_range, results.in_range);
						fail_tally++;
					end
				end
			end
			if (pairs.valid && pairs.ready) begin
				if (pairs.func == FUNC_WRITE) begin
					if (pairs.entry_index < DEPTH)
						pot_tbl[pairs.table_sel][pairs.entry_index] = pairs.entry_value;
				end else begin
					outcome_q.push_back(interpolate(
						(pairs.type_a[1] == pairs.type_b[1]) ? TBL_LIKE : TBL_UNLIKE,
						pairs.dist_sq));
				end
			end
			errors  <= fail_tally;
			pending <= outcome_q.size();
		end
	end

endmodule

### bench/pair_potential_table_interp_tb.sv
// pair_potential_table_interp_tb: drives table writes, pair evaluations and register
// settings into the block and gives the verdict; depends on pptint_pkg, both channel
// interfaces, pptint_checker and the block itself
module pair_potential_table_interp_tb;
	timeunit 1ns;
	timeprecision 1ps;
	import pptint_pkg::*;

	localparam int DEPTH       = 1024;
	localparam int DRAIN       = 12;	// margin for the pipeline to empty after the last result
	localparam int PHASES      = 8;
	localparam int PHASE_ITEMS = 220;

	logic              clk;
	logic              arst_n;
	logic              psel;
	logic              penable;
	logic              pwrite;
	logic [ADDR_W-1:0] paddr;
	logic [DATA_W-1:0] pwdata;
	logic [DATA_W-1:0] prdata;
	logic              pready;
	int                errors;
	int                pending;

	pptint_req_if pairs ();
	pptint_rsp_if results ();

	pair_potential_table_interp #(
		.TABLE_DEPTH (DEPTH)
	) dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.pairs   (pairs),
		.results (results),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready)
	);

	pptint_checker #(
		.DEPTH (DEPTH)
	) u_check (
		.clk     (clk),
		.arst_n  (arst_n),
		.pairs   (pairs),
		.results (results),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.pready  (pready),
		.errors  (errors),
		.pending (pending)
	);

	// mirror of the registers, so that evaluations only read entries already loaded
	logic [DATA_W-1:0] step_m [2];
	logic [DATA_W-1:0] inv_m [2];
	logic [DATA_W-1:0] cut_m [2];
	bit                loaded [2][DEPTH];
	bit                calm;	// sender runs back to back while set
	int                n_writes;
	int                n_evals;
	int                n_settings;

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	// generous ceiling on the whole run
	initial begin
		#8ms;
		$display("== FAIL ==");
		$finish;
	end

	// mostly short gaps, now and then a long one
	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		if (r < 85)
			return $urandom_range(1, 3);
		if (r < 97)
			return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	// signed Q16.16 table values, extremes included
	function automatic logic [DATA_W-1:0] pick_value();
		case ($urandom_range(0, 9))
			0: return 32'h8000_0000;
			1: return 32'h7FFF_FFFF;
			2: return 32'h0000_0000;
			3: return 32'hFFFF_FFFF;
			4, 5: return 32'($urandom_range(0, 32'h3F_FFFF)) - 32'h20_0000;
			default: return $urandom;
		endcase
	endfunction

	// result channel back-pressure: long open stretches and random stalls
	initial begin
		results.ready <= 1'b0;
		@(posedge clk);
		forever begin
			int gap;
			if ($urandom_range(0, 4) == 0) begin
				results.ready <= 1'b1;
				repeat ($urandom_range(30, 200)) @(posedge clk);
			end else begin
				gap = pick_gap();
				if (gap > 0) begin
					results.ready <= 1'b0;
					repeat (gap) @(posedge clk);
				end
				results.ready <= 1'b1;
				repeat ($urandom_range(1, 8)) @(posedge clk);
			end
		end
	end

	// one item on the pairs channel, returns at the edge that takes it
	task automatic send(func_t fn, logic [TYPE_W-1:0] ta, logic [TYPE_W-1:0] tb,
			logic [DIST_W-1:0] d, tbl_t sel, logic [INDEX_W-1:0] idx,
			logic [DATA_W-1:0] val);
		int gap;
		gap = calm ? 0 : pick_gap();
		if (gap > 0) begin
			pairs.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		pairs.valid       <= 1'b1;
		pairs.func        <= fn;
		pairs.type_a      <= ta;
		pairs.type_b      <= tb;
		pairs.dist_sq     <= d;
		pairs.table_sel   <= sel;
		pairs.entry_index <= idx;
		pairs.entry_value <= val;
		do @(posedge clk); while (!pairs.ready);
	endtask

	// table write; the evaluate fields carry noise
	task automatic load(tbl_t t, logic [INDEX_W-1:0] idx, logic [DATA_W-1:0] val);
		send(FUNC_WRITE, TYPE_W'($urandom_range(0, 3)), TYPE_W'($urandom_range(0, 3)),
			$urandom, t, idx, val);
		loaded[t][idx] = 1'b1;
		n_writes++;
	endtask

	// pair evaluation; entries it will read are loaded first if still blank
	task automatic eval_pair(logic [TYPE_W-1:0] ta, logic [TYPE_W-1:0] tb,
			logic [DIST_W-1:0] d);
		tbl_t        t;
		logic [63:0] prod;
		logic [31:0] upper;
		t = (ta[1] == tb[1]) ? TBL_LIKE : TBL_UNLIKE;
		if (d < step_m[t]) begin
			if (!loaded[t][0])
				load(t, '0, pick_value());
		end else if (d < cut_m[t]) begin
			prod  = {32'd0, d} * {32'd0, inv_m[t]};
			upper = prod[63:32];
			if (upper == 0)
				upper = 1;
			else if (upper > DEPTH - 1)
				upper = DEPTH - 1;
			if (!loaded[t][upper - 1])
				load(t, INDEX_W'(upper - 1), pick_value());
			if (!loaded[t][upper])
				load(t, INDEX_W'(upper), pick_value());
		end
		send(FUNC_EVAL, ta, tb, d, tbl_t'($urandom_range(0, 1)),
			INDEX_W'($urandom_range(0, DEPTH - 1)), $urandom);
		n_evals++;
	endtask

	// distances biased towards the interesting regions of the chosen table
	task automatic random_eval();
		logic [TYPE_W-1:0] ta;
		logic [TYPE_W-1:0] tb;
		logic [DIST_W-1:0] d;
		logic [DATA_W-1:0] s;
		logic [DATA_W-1:0] c;
		int                r;
		tbl_t              t;
		ta = TYPE_W'($urandom_range(0, 3));
		tb = TYPE_W'($urandom_range(0, 3));
		t  = (ta[1] == tb[1]) ? TBL_LIKE : TBL_UNLIKE;
		s  = step_m[t];
		c  = cut_m[t];
		r  = $urandom_range(0, 99);
		if (r < 55 && c > s)
			d = $urandom_range(c - 1, s);
		else if (r < 70 && s > 0)
			d = $urandom_range(s - 1, 0);
		else if (r < 80)
			d = c + 32'($urandom_range(0, 2)) - 32'd1;
		else if (r < 85)
			d = s + 32'($urandom_range(0, 2)) - 32'd1;
		else if (r < 90)
			d = r[0] ? 32'hFFFF_FFFF : 32'h0;
		else
			d = $urandom;
		eval_pair(ta, tb, d);
	endtask

	// apb write: setup, access, then idle
	task automatic cfg_write(reg_idx_t r, logic [DATA_W-1:0] v);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {r, 2'b00};
		pwdata  <= v;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel    <= 1'b0;
		penable <= 1'b0;
		@(posedge clk);
		case (r)
			REG_LIKE_STEP:   step_m[TBL_LIKE]   = v;
			REG_LIKE_INV:    inv_m[TBL_LIKE]    = v;
			REG_LIKE_CUT:    cut_m[TBL_LIKE]    = v;
			REG_UNLIKE_STEP: step_m[TBL_UNLIKE] = v;
			REG_UNLIKE_INV:  inv_m[TBL_UNLIKE]  = v;
			REG_UNLIKE_CUT:  cut_m[TBL_UNLIKE]  = v;
			default: ;
		endcase
	endtask

	task automatic program_table(tbl_t t, logic [DATA_W-1:0] s, logic [DATA_W-1:0] v,
			logic [DATA_W-1:0] c);
		cfg_write(t == TBL_LIKE ? REG_LIKE_STEP : REG_UNLIKE_STEP, s);
		cfg_write(t == TBL_LIKE ? REG_LIKE_INV : REG_UNLIKE_INV, v);
		cfg_write(t == TBL_LIKE ? REG_LIKE_CUT : REG_UNLIKE_CUT, c);
	endtask

	// ordinary table: reciprocal a little off now and then, index up to past the end
	task automatic nominal(tbl_t t);
		logic [DATA_W-1:0] s;
		logic [DATA_W-1:0] v;
		logic [63:0]       c;
		s = $urandom_range(32'h4_0000, 32'h100);
		v = 32'(64'h1_0000_0000 / s);
		v = v + 32'($urandom_range(0, 2)) - 32'd1;
		c = 64'(s) * $urandom_range(2, 1200);
		if (c > 64'hFFFF_FFFF)
			c = 64'hFFFF_FFFF;
		program_table(t, s, v, c[31:0]);
	endtask

	// wait until every result is back, then let the pipeline empty of writes
	task automatic drain();
		pairs.valid <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (DRAIN) @(posedge clk);
	endtask

	initial begin
		int goal;
		arst_n            <= 1'b0;
		psel              <= 1'b0;
		penable           <= 1'b0;
		pwrite            <= 1'b0;
		paddr             <= '0;
		pwdata            <= '0;
		pairs.valid       <= 1'b0;
		pairs.func        <= FUNC_WRITE;
		pairs.type_a      <= '0;
		pairs.type_b      <= '0;
		pairs.dist_sq     <= '0;
		pairs.table_sel   <= TBL_LIKE;
		pairs.entry_index <= '0;
		pairs.entry_value <= '0;
		step_m[TBL_LIKE]   = STEP_RESET;
		step_m[TBL_UNLIKE] = STEP_RESET;
		inv_m[TBL_LIKE]    = INV_RESET;
		inv_m[TBL_UNLIKE]  = INV_RESET;
		cut_m[TBL_LIKE]    = CUT_RESET;
		cut_m[TBL_UNLIKE]  = CUT_RESET;
		calm       = 1'b0;
		n_writes   = 0;
		n_evals    = 0;
		n_settings = 1;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset settings: below one step gives entry 0, anything else is past a zero cutoff
		load(TBL_LIKE, '0, 32'h7FFF_FFFF);
		load(TBL_UNLIKE, '0, 32'h8000_0000);
		eval_pair(2'd0, 2'd1, 32'h0000_0000);
		eval_pair(2'd0, 2'd2, 32'h0001_0000);
		drain();

		// spare addresses must leave the table registers alone
		cfg_write(REG_SPARE6, 32'hFFFF_FFFF);
		cfg_write(REG_SPARE7, 32'h0000_0000);
		program_table(TBL_LIKE, 32'h0001_0000, 32'h0001_0000, 32'hFFFF_FFFF);
		program_table(TBL_UNLIKE, 32'h0002_0000, 32'h0000_8000, 32'h1000_0000);
		n_settings++;
		load(TBL_LIKE, 10'd1, 32'h8000_0000);
		load(TBL_LIKE, 10'd2, 32'h0000_0000);
		load(TBL_LIKE, 10'd1022, 32'h0000_3039);
		load(TBL_LIKE, 10'd1023, 32'hFFFF_FCF7);
		load(TBL_UNLIKE, 10'd1023, 32'h7FFF_FFFF);
		// interpolation across the widest possible swing
		eval_pair(2'd2, 2'd3, 32'h0001_8000);
		eval_pair(2'd3, 2'd2, 32'h0002_FFFF);
		// at the cutoff and at the top of the distance range
		eval_pair(2'd1, 2'd0, 32'hFFFF_FFFF);
		// index past the last entry saturates onto it
		eval_pair(2'd0, 2'd0, 32'hFFFF_FFFE);
		eval_pair(2'd0, 2'd2, 32'h0001_FFFF);
		eval_pair(2'd1, 2'd3, 32'h1000_0000);
		eval_pair(2'd3, 2'd0, 32'h0003_0000);
		eval_pair(2'd2, 2'd1, 32'h0FFF_FFFF);
		drain();

		// inexact reciprocal gives index zero; zero step never takes the below-step path
		program_table(TBL_LIKE, 32'h0001_0000, 32'h0000_8000, 32'h0010_0000);
		program_table(TBL_UNLIKE, 32'h0000_0000, 32'h0001_0000, 32'h0005_0000);
		n_settings++;
		eval_pair(2'd0, 2'd1, 32'h0001_8000);
		eval_pair(2'd0, 2'd3, 32'h0000_0000);
		eval_pair(2'd1, 2'd2, 32'h0002_8000);
		drain();

		// cutoff below the step: entry 0 still wins below one step
		program_table(TBL_LIKE, 32'h0001_0000, 32'h0001_0000, 32'h0000_8000);
		n_settings++;
		eval_pair(2'd1, 2'd1, 32'h0000_4000);
		eval_pair(2'd1, 2'd1, 32'h0001_0000);

		// random phases, each under its own settings
		for (int p = 0; p < PHASES; p++) begin
			drain();
			case (p)
				0: begin
					program_table(TBL_LIKE, 32'h0000_0001, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
					nominal(TBL_UNLIKE);
				end
				1: begin
					nominal(TBL_LIKE);
					program_table(TBL_UNLIKE, 32'hFFFF_FFFF, 32'h0000_0001, 32'hFFFF_FFFF);
				end
				2: begin
					program_table(TBL_LIKE, 32'h0000_0000, $urandom_range(32'h2_0000, 32'h100),
						$urandom_range(32'h400_0000, 32'h1_0000));
					nominal(TBL_UNLIKE);
					cfg_write(REG_UNLIKE_CUT, 32'h0000_0000);
				end
				3: begin
					program_table(TBL_LIKE, 32'h0001_0000, 32'h0000_0000, 32'hFFFF_FFFF);
					nominal(TBL_UNLIKE);
				end
				default: begin
					nominal(TBL_LIKE);
					nominal(TBL_UNLIKE);
				end
			endcase
			n_settings++;
			goal = n_writes + n_evals + PHASE_ITEMS;
			while (n_writes + n_evals < goal) begin
				if ($urandom_range(0, 39) == 0)
					calm = ($urandom_range(0, 2) == 0);
				if ($urandom_range(0, 99) < 15)
					load(tbl_t'($urandom_range(0, 1)), INDEX_W'($urandom_range(0, DEPTH - 1)),
						pick_value());
				else
					random_eval();
			end
			calm = 1'b0;
		end

		drain();
		$display("covered %0d table writes and %0d pair evaluations under %0d register settings",
			n_writes, n_evals, n_settings);
		if (errors == 0 && pending == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

endmodule

### sim.f
sv/pptint_pkg.sv
sv/pptint_req_if.sv
sv/pptint_rsp_if.sv
sv/pptint_ram.sv
sv/pair_potential_table_interp.sv
bench/pptint_checker.sv
bench/pair_potential_table_interp_tb.sv
